// ===== src/fpa_pkg.sv =====
// fpa_pkg: shared types and constants of the flash log page allocator
// holds the action and status codes, controller states and the command/status structs
// no dependencies
package fpa_pkg;

    // block bitmap rows: 32 blocks per row, used bits low half, map-valid bits high half
    localparam int BMP_W  = 32;
    localparam int BMP_SH = 5;
    localparam int FLAG_W = 2 * BMP_W;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_PER_BLOCK = 4'd1;

    localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_SCAN   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_FORMAT = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_REFUSED = 2'd1,
        STS_FAILED  = 2'd2,
        STS_FULL    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_DISPATCH,
        FSM_READ,
        FSM_UPDATE,
        FSM_SRCH_RD,
        FSM_SRCH_CHK,
        FSM_CLEAR,
        FSM_FMT,
        FSM_DONE
    } fsm_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    set_status;
        status_t status_val;
        logic    item_rd;
        logic    item_upd;
        logic    row_clr;
        logic    clear_wr;
        logic    fmt_fin;
        logic    srch_rd;
        logic    srch_chk;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        action_t act;
        logic    in_geo;
        logic    hit;
        logic    ptr_bad;
        logic    ok;
        logic    need_wrap;
        logic    row_end;
        logic    row_lim;
        logic    found;
    } dp_stat_t;

endpackage

// ===== src/fpa_ctrl.sv =====
// fpa_ctrl: sequencing state machine of the flash log page allocator
// steps each item through decode, map read/update, free-block search and clearing
// depends on fpa_pkg
module fpa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fpa_pkg::dp_stat_t stat,
    output fpa_pkg::ctl_t    ctl,
    output logic             busy,
    output logic             done
);
    import fpa_pkg::*;

    fsm_t state_reg;
    fsm_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            FSM_INIT:
            begin
                // bitmap clearing pass after reset
                ctl.clear_wr = 1'b1;
                if (stat.row_end)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = FSM_DISPATCH;
                end
            end
            FSM_DONE:
            begin
                busy = 1'b0;
                done = 1'b1;
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = FSM_DISPATCH;
                end
                else
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_DISPATCH:
            begin
                case (stat.act)
                    ACT_SCAN:
                    begin
                        state_next = (stat.in_geo && stat.hit) ? FSM_READ : FSM_DONE;
                    end
                    ACT_WRITE:
                    begin
                        if (stat.ptr_bad)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status_val = STS_REFUSED;
                            state_next     = FSM_DONE;
                        end
                        else if (!stat.ok)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status_val = STS_FAILED;
                            state_next     = FSM_DONE;
                        end
                        else
                        begin
                            state_next = FSM_READ;
                        end
                    end
                    ACT_FORMAT:
                    begin
                        if (!stat.ok)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status_val = STS_FAILED;
                            state_next     = FSM_DONE;
                        end
                        else
                        begin
                            ctl.row_clr = 1'b1;
                            state_next  = FSM_CLEAR;
                        end
                    end
                    ACT_QUERY:
                    begin
                        state_next = stat.in_geo ? FSM_READ : FSM_DONE;
                    end
                    default:
                    begin
                        state_next = FSM_DONE;
                    end
                endcase
            end
            FSM_READ:
            begin
                ctl.item_rd = 1'b1;
                state_next  = FSM_UPDATE;
            end
            FSM_UPDATE:
            begin
                ctl.item_upd = 1'b1;
                if (stat.act == ACT_WRITE && stat.need_wrap)
                begin
                    ctl.row_clr = 1'b1;
                    state_next  = FSM_SRCH_RD;
                end
                else
                begin
                    state_next = FSM_DONE;
                end
            end
            FSM_SRCH_RD:
            begin
                ctl.srch_rd = 1'b1;
                state_next  = FSM_SRCH_CHK;
            end
            FSM_SRCH_CHK:
            begin
                ctl.srch_chk = 1'b1;
                state_next   = (stat.found || stat.row_lim) ? FSM_DONE : FSM_SRCH_RD;
            end
            FSM_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
                if (stat.row_end)
                begin
                    state_next = FSM_FMT;
                end
            end
            FSM_FMT:
            begin
                ctl.fmt_fin = 1'b1;
                state_next  = FSM_DONE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

// ===== src/fpa_datapath.sv =====
// fpa_datapath: registers, block bitmap memory and page map memory of the allocator
// performs map updates, free-block search, pointer moves and the configuration registers
// depends on fpa_pkg
module fpa_datapath #(
    parameter int MAX_BLOCKS          = 1024,
    parameter int MAX_PAGES_PER_BLOCK = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fpa_pkg::ctl_t                     ctl,
    output fpa_pkg::dp_stat_t                 stat,
    input  logic [1:0]                        action,
    input  logic [9:0]                        block_index,
    input  logic [5:0]                        page_offset,
    input  logic [31:0]                       first_word,
    input  logic                              flash_ok,
    output logic [1:0]                        status,
    output logic [15:0]                       target_page,
    output logic [9:0]                        write_block,
    output logic [5:0]                        write_offset,
    output logic                              read_only_now,
    output logic                              page_holds_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fpa_pkg::*;

    localparam int BW      = $clog2(MAX_BLOCKS);
    localparam int NBW     = $clog2(MAX_BLOCKS + 1);
    localparam int MAXP    = MAX_PAGES_PER_BLOCK;
    localparam int OW      = (MAXP > 1) ? $clog2(MAXP) : 1;
    localparam int PW      = $clog2(MAXP + 1);
    localparam int ROWS    = (MAX_BLOCKS + BMP_W - 1) / BMP_W;
    localparam int RW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int XW      = BW + BMP_SH;
    localparam int NXW     = NBW + BMP_SH;
    localparam int TW      = BW + PW;
    localparam int RST_NB  = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;
    localparam int RST_PPB = (MAXP < 64) ? MAXP : 64;

    // configuration, held as effective (clamped) values
    logic [NBW-1:0]    nb_reg;
    logic [PW-1:0]     ppb_reg;
    logic [NBW-1:0]    nb_clamp;
    logic [PW-1:0]     ppb_clamp;

    // latched item
    action_t           act_reg;
    logic [9:0]        blk_reg;
    logic [5:0]        off_reg;
    logic              hit_reg;
    logic              ok_reg;

    // allocator state
    logic [BW-1:0]     ptr_blk_reg;
    logic [OW-1:0]     ptr_off_reg;
    logic              full_reg;
    logic [RW-1:0]     row_reg;

    // result
    status_t           status_reg;
    logic [15:0]       target_reg;
    logic              holds_reg;

    // memories and read data
    logic [FLAG_W-1:0] flag_mem [ROWS];
    logic [MAXP-1:0]   page_mem [MAX_BLOCKS];
    logic [FLAG_W-1:0] flag_q_reg;
    logic [MAXP-1:0]   page_q_reg;

    logic              flag_we;
    logic [RW-1:0]     flag_wa;
    logic [FLAG_W-1:0] flag_wd;
    logic              flag_re;
    logic [RW-1:0]     flag_ra;
    logic              page_we;
    logic              mark_item;

    logic [BW-1:0]     item_blk;
    logic [OW-1:0]     item_off;
    logic [XW-1:0]     item_x;
    logic [RW-1:0]     item_row;
    logic [BMP_SH-1:0] item_bit;
    logic              mapped;
    logic [MAXP-1:0]   page_new;
    logic [FLAG_W-1:0] flag_new_item;

    logic              in_geo;
    logic              ptr_bad;
    logic              need_wrap;
    logic              scan_last;
    logic [NBW-1:0]    nbm1;
    logic [NXW-1:0]    lim_x;
    logic [RW-1:0]     lim_row;
    logic [BMP_SH-1:0] lim_bit;
    logic              row_end;
    logic              row_lim;

    logic [BMP_W-1:0]  free_bits;
    logic              found;
    logic [BMP_SH-1:0] fbit;
    logic [BW-1:0]     found_blk;
    logic [TW-1:0]     tgt_full;

    // config clamping
    always_comb
    begin
        if (cfg_data == '0)
        begin
            nb_clamp = NBW'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_BLOCKS))
        begin
            nb_clamp = NBW'(MAX_BLOCKS);
        end
        else
        begin
            nb_clamp = NBW'(cfg_data);
        end

        if (cfg_data[6:0] == 7'd0)
        begin
            ppb_clamp = PW'(1);
        end
        else if (32'(cfg_data[6:0]) > 32'(MAXP))
        begin
            ppb_clamp = PW'(MAXP);
        end
        else
        begin
            ppb_clamp = PW'(cfg_data[6:0]);
        end
    end

    assign cfg_ready = 1'b1;

    // item addressing: a write goes to the pointer, scan and query to the given page
    assign item_blk = (act_reg == ACT_WRITE) ? ptr_blk_reg : BW'(blk_reg);
    assign item_off = (act_reg == ACT_WRITE) ? ptr_off_reg : OW'(off_reg);
    assign item_x   = XW'(item_blk);
    assign item_row = RW'(item_x >> BMP_SH);
    assign item_bit = item_x[BMP_SH-1:0];

    // a map entry whose map-valid bit is clear reads as empty
    assign mapped        = flag_q_reg[BMP_W + int'(item_bit)];
    assign page_new      = (mapped ? page_q_reg : '0) | (MAXP'(1) << item_off);
    assign flag_new_item = flag_q_reg | (FLAG_W'(1) << item_bit)
                                      | (FLAG_W'(1) << (BMP_W + int'(item_bit)));

    assign in_geo    = (32'(blk_reg) < 32'(nb_reg)) && (32'(off_reg) < 32'(ppb_reg));
    assign ptr_bad   = full_reg || (32'(ptr_blk_reg) >= 32'(nb_reg))
                                || (32'(ptr_off_reg) >= 32'(ppb_reg));
    assign need_wrap = (32'(ptr_off_reg) + 32'd1) >= 32'(ppb_reg);
    assign nbm1      = nb_reg - NBW'(1);
    assign scan_last = (32'(blk_reg) == 32'(nbm1)) && ((32'(off_reg) + 32'd1) == 32'(ppb_reg));
    assign lim_x     = NXW'(nbm1);
    assign lim_row   = RW'(lim_x >> BMP_SH);
    assign lim_bit   = lim_x[BMP_SH-1:0];
    assign row_end   = (row_reg == RW'(ROWS - 1));
    assign row_lim   = (row_reg == lim_row);

    // lowest free block in the current bitmap row, ignoring blocks past the partition end
    always_comb
    begin
        free_bits = ~flag_q_reg[BMP_W-1:0];
        for (int b = 0; b < BMP_W; b++)
        begin
            if (row_lim && (BMP_SH'(b) > lim_bit))
            begin
                free_bits[b] = 1'b0;
            end
        end
        fbit = '0;
        for (int b = BMP_W - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                fbit = BMP_SH'(b);
            end
        end
    end

    assign found     = |free_bits;
    assign found_blk = BW'({row_reg, fbit});
    assign tgt_full  = TW'(ptr_blk_reg) * TW'(ppb_reg) + TW'(ptr_off_reg);

    // memory port steering
    assign mark_item = ctl.item_upd && (act_reg != ACT_QUERY);
    assign page_we   = mark_item;

    always_comb
    begin
        flag_we = 1'b0;
        flag_wa = row_reg;
        flag_wd = '0;
        if (ctl.clear_wr)
        begin
            flag_we = 1'b1;
        end
        else if (ctl.fmt_fin)
        begin
            // block 0 is taken by the fresh log
            flag_we = 1'b1;
            flag_wa = '0;
            flag_wd = FLAG_W'(1);
        end
        else if (mark_item)
        begin
            flag_we = 1'b1;
            flag_wa = item_row;
            flag_wd = flag_new_item;
        end
        else if (ctl.srch_chk && found)
        begin
            flag_we = 1'b1;
            flag_wd = flag_q_reg | (FLAG_W'(1) << fbit);
        end
    end

    assign flag_re = ctl.item_rd || ctl.srch_rd;
    assign flag_ra = ctl.item_rd ? item_row : row_reg;

    always_ff @(posedge clk)
    begin
        if (flag_re)
        begin
            flag_q_reg <= flag_mem[flag_ra];
        end
        if (flag_we)
        begin
            flag_mem[flag_wa] <= flag_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.item_rd)
        begin
            page_q_reg <= page_mem[item_blk];
        end
        if (page_we)
        begin
            page_mem[item_blk] <= page_new;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg      <= NBW'(RST_NB);
            ppb_reg     <= PW'(RST_PPB);
            ptr_blk_reg <= '0;
            ptr_off_reg <= '0;
            full_reg    <= 1'b0;
            row_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BLOCK_COUNT:     nb_reg  <= nb_clamp;
                    CFG_PAGES_PER_BLOCK: ppb_reg <= ppb_clamp;
                    default:             ;
                endcase
            end

            if (ctl.row_clr)
            begin
                row_reg <= '0;
            end
            else if (ctl.clear_wr || (ctl.srch_chk && !found && !row_lim))
            begin
                row_reg <= row_reg + RW'(1);
            end

            if (ctl.item_upd)
            begin
                case (act_reg)
                    ACT_SCAN:
                    begin
                        if (scan_last)
                        begin
                            full_reg <= 1'b1;
                        end
                    end
                    ACT_WRITE:
                    begin
                        if (!need_wrap)
                        begin
                            ptr_off_reg <= ptr_off_reg + OW'(1);
                        end
                    end
                    default: ;
                endcase
            end

            if (ctl.srch_chk)
            begin
                if (found)
                begin
                    ptr_blk_reg <= found_blk;
                    ptr_off_reg <= '0;
                end
                else if (row_lim)
                begin
                    full_reg <= 1'b1;
                end
            end

            if (ctl.fmt_fin)
            begin
                ptr_blk_reg <= '0;
                ptr_off_reg <= '0;
                full_reg    <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            act_reg    <= action_t'(action);
            blk_reg    <= block_index;
            off_reg    <= page_offset;
            hit_reg    <= (first_word != ERASED_WORD);
            ok_reg     <= flash_ok;
            status_reg <= STS_OK;
            target_reg <= '0;
            holds_reg  <= 1'b0;
        end
        if (ctl.set_status)
        begin
            status_reg <= ctl.status_val;
        end
        if (ctl.item_upd)
        begin
            if (act_reg == ACT_WRITE)
            begin
                target_reg <= 16'(tgt_full);
            end
            if (act_reg == ACT_QUERY)
            begin
                holds_reg <= mapped && page_q_reg[item_off];
            end
        end
        if (ctl.srch_chk && !found && row_lim)
        begin
            status_reg <= STS_FULL;
        end
    end

    always_comb
    begin
        stat.act       = act_reg;
        stat.in_geo    = in_geo;
        stat.hit       = hit_reg;
        stat.ptr_bad   = ptr_bad;
        stat.ok        = ok_reg;
        stat.need_wrap = need_wrap;
        stat.row_end   = row_end;
        stat.row_lim   = row_lim;
        stat.found     = found;
    end

    assign status          = status_reg;
    assign target_page     = target_reg;
    assign write_block     = 10'(ptr_blk_reg);
    assign write_offset    = 6'(ptr_off_reg);
    assign read_only_now   = full_reg;
    assign page_holds_data = holds_reg;

endmodule

// ===== src/flash_log_page_allocator_core.sv =====
// flash_log_page_allocator_core: top level of the append-only flash page allocator
// joins the controller (fpa_ctrl) and the datapath (fpa_datapath)
// depends on fpa_pkg, fpa_ctrl, fpa_datapath
//
// usage
//   command channel: an item (action, block_index, page_offset, first_word, flash_ok)
//   is taken at a rising edge with start high and busy low. exactly one result per
//   item appears on the result ports, marked by done high for one cycle; the receiver
//   cannot stall, and a new item may be started in the cycle that done is high.
//   config channel: cfg_valid/cfg_ready/cfg_index/cfg_data, register 0 block count,
//   register 1 pages per block; cfg_ready is always high, write only while idle.
// sequence, from the accepting edge to done
//   refused, failed, out-of-range or erased-page items: dispatch, then done
//   scan, query, write inside a block: map read, then read-modify-write, then done
//   write that fills a block: map read and update, then a read and check per 32-block
//   bitmap row searched for a free block; format: clearing pass over every bitmap row
// reset: a clearing pass over every bitmap row runs with busy high; config
//   writes are taken throughout. the page map itself is never swept, its entries are
//   qualified by a per-block map-valid bit held in the bitmap.
module flash_log_page_allocator_core #(
    parameter int MAX_BLOCKS          = 1024,
    parameter int MAX_PAGES_PER_BLOCK = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic [1:0]                        action,
    input  logic [9:0]                        block_index,
    input  logic [5:0]                        page_offset,
    input  logic [31:0]                       first_word,
    input  logic                              flash_ok,
    output logic [1:0]                        status,
    output logic [15:0]                       target_page,
    output logic [9:0]                        write_block,
    output logic [5:0]                        write_offset,
    output logic                              read_only_now,
    output logic                              page_holds_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fpa_pkg::*;

    ctl_t     ctl;
    dp_stat_t stat;

    fpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    fpa_datapath #(
        .MAX_BLOCKS          (MAX_BLOCKS),
        .MAX_PAGES_PER_BLOCK (MAX_PAGES_PER_BLOCK)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .stat            (stat),
        .action          (action),
        .block_index     (block_index),
        .page_offset     (page_offset),
        .first_word      (first_word),
        .flash_ok        (flash_ok),
        .status          (status),
        .target_page     (target_page),
        .write_block     (write_block),
        .write_offset    (write_offset),
        .read_only_now   (read_only_now),
        .page_holds_data (page_holds_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

endmodule
